FILE: hdl/byte_stream_tokenizer_defines.svh
// Assertion macros for the byte stream tokenizer
`ifndef BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define BST_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tokenizer check failed");

// Next-cycle implication, checked out of reset
`define BST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tokenizer check failed");

`endif

FILE: hdl/bst_pkg.sv
// Types, codes and character classes shared by the tokenizer modules
package bst_pkg;

	// token kinds
	localparam logic [2:0] KIND_SKIP    = 3'd0;
	localparam logic [2:0] KIND_SYMBOL  = 3'd1;
	localparam logic [2:0] KIND_QUOTED  = 3'd2;
	localparam logic [2:0] KIND_NUMBER  = 3'd3;
	localparam logic [2:0] KIND_SPECIAL = 3'd4;
	localparam logic [2:0] KIND_PUNCT   = 3'd5;
	localparam logic [2:0] KIND_WORD    = 3'd6;
	localparam logic [2:0] KIND_END     = 3'd7;

	// error codes
	localparam logic [1:0] ERR_NONE    = 2'd0;
	localparam logic [1:0] ERR_ILLEGAL = 2'd1;
	localparam logic [1:0] ERR_NOCLOSE = 2'd2;

	// lexer states
	localparam logic [3:0] ST_IDLE       = 4'd0;
	localparam logic [3:0] ST_SYMBOL     = 4'd1;
	localparam logic [3:0] ST_QUOTE      = 4'd2;
	localparam logic [3:0] ST_NUM_INT    = 4'd3;
	localparam logic [3:0] ST_NUM_DOT    = 4'd4;
	localparam logic [3:0] ST_NUM_FRAC   = 4'd5;
	localparam logic [3:0] ST_NUM_EXP    = 4'd6;
	localparam logic [3:0] ST_NUM_EXPDIG = 4'd7;
	localparam logic [3:0] ST_COMMENT    = 4'd8;
	localparam logic [3:0] ST_MINUS      = 4'd9;
	localparam logic [3:0] ST_PUNCT      = 4'd10;
	localparam logic [3:0] ST_WORD       = 4'd11;

	// characters of note
	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_UNDER   = 8'h5F;
	localparam logic [7:0] CH_QUOTE   = 8'h27;
	localparam logic [7:0] CH_E_LO    = 8'h65;
	localparam logic [7:0] CH_E_UP    = 8'h45;
	localparam logic [7:0] CH_PERIOD  = 8'h2E;
	localparam logic [7:0] CH_COMMA   = 8'h2C;
	localparam logic [7:0] CH_QMARK   = 8'h3F;
	localparam logic [7:0] CH_LPAREN  = 8'h28;
	localparam logic [7:0] CH_RPAREN  = 8'h29;
	localparam logic [7:0] CH_LF      = 8'h0A;
	localparam logic [7:0] CH_NUL     = 8'h00;

	// one labelled byte, without its line number
	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] kind;
		logic       start;
		logic [1:0] err;
	} bst_res_t;

	localparam int RES_W = $bits(bst_res_t);

	// outcome of one lexer decision
	typedef struct packed {
		logic [3:0] st;
		logic       emit;
		logic       nl;
		bst_res_t   res;
	} bst_step_t;

	function automatic logic is_blank(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	function automatic logic is_special(input logic [7:0] c);
		return c == CH_COMMA || c == CH_PERIOD || c == CH_LPAREN ||
			c == CH_RPAREN || c == CH_QMARK;
	endfunction

	function automatic logic is_graph(input logic [7:0] c);
		return c >= 8'd33 && c <= 8'd126;
	endfunction

	function automatic bst_res_t mk_res(input logic [7:0] c, input logic [2:0] k,
		input logic s, input logic [1:0] e);
		bst_res_t r;
		r.ch = c;
		r.kind = k;
		r.start = s;
		r.err = e;
		return r;
	endfunction

endpackage

FILE: hdl/bst_front.sv
// Front end: mode register, lexer state, line counter and per-byte classification
module bst_front import bst_pkg::*; #(
	parameter int LINE_BITS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic                 cfg_data,
	input  logic                 in_acc,
	input  logic [7:0]           char_in,
	input  logic                 end_of_input,
	output logic                 q_push,
	output bst_res_t             q_res0,
	output bst_res_t             q_res1,
	output logic                 q_two,
	output logic [LINE_BITS-1:0] q_line
);

	localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};
	localparam logic [LINE_BITS-1:0] LINE_ONE = {{(LINE_BITS-1){1'b0}}, 1'b1};

	logic                 word_mode_q;
	logic [3:0]           st_q;
	logic [LINE_BITS-1:0] line_q;

	logic       emit0, emit1, bump, line_rst;
	logic [3:0] st_nxt;
	bst_step_t  h;

	// byte at a token start
	function automatic bst_step_t tok_start(input logic [7:0] c, input logic wm);
		bst_step_t s;
		s.st = ST_IDLE;
		s.emit = 1'b1;
		s.nl = 1'b0;
		s.res = mk_res(c, KIND_SKIP, 1'b0, ERR_NONE);
		if (is_blank(c)) begin
			s.nl = (c == CH_LF);
		end else if (c == CH_QUOTE) begin
			s.st = ST_QUOTE;
			s.res = mk_res(c, KIND_QUOTED, 1'b1, ERR_NONE);
		end else if (wm) begin
			if (c == CH_PERIOD || c == CH_COMMA) begin
				s.res = mk_res(c, KIND_SPECIAL, 1'b1, ERR_NONE);
			end else if (is_graph(c)) begin
				s.st = ST_WORD;
				s.res = mk_res(c, KIND_WORD, 1'b1, ERR_NONE);
			end else begin
				s.res = mk_res(c, KIND_SKIP, 1'b0, ERR_ILLEGAL);
			end
		end else if (is_alpha(c) || c == CH_UNDER) begin
			s.st = ST_SYMBOL;
			s.res = mk_res(c, KIND_SYMBOL, 1'b1, ERR_NONE);
		end else if (is_digit(c)) begin
			s.st = ST_NUM_INT;
			s.res = mk_res(c, KIND_NUMBER, 1'b1, ERR_NONE);
		end else if (c == CH_PERCENT) begin
			s.st = ST_COMMENT;
		end else if (c == CH_MINUS) begin
			// held until the next byte decides number or punct
			s.st = ST_MINUS;
			s.emit = 1'b0;
		end else if (is_special(c)) begin
			s.res = mk_res(c, KIND_SPECIAL, 1'b1, ERR_NONE);
		end else if (is_punct(c)) begin
			s.st = ST_PUNCT;
			s.res = mk_res(c, KIND_PUNCT, 1'b1, ERR_NONE);
		end else begin
			s.res = mk_res(c, KIND_SKIP, 1'b0, ERR_ILLEGAL);
		end
		return s;
	endfunction

	// continuation byte of the current token
	function automatic bst_step_t cont(input logic [3:0] st, input logic [7:0] c,
		input logic [2:0] k);
		bst_step_t s;
		s.st = st;
		s.emit = 1'b1;
		s.nl = 1'b0;
		s.res = mk_res(c, k, 1'b0, ERR_NONE);
		return s;
	endfunction

	// byte in a running state; falls back to a fresh token start
	function automatic bst_step_t tok_handle(input logic [3:0] st, input logic [7:0] c,
		input logic wm);
		bst_step_t s;
		s = tok_start(c, wm);
		case (st)
			ST_SYMBOL: begin
				if (is_alpha(c) || is_digit(c) || c == CH_UNDER)
					s = cont(ST_SYMBOL, c, KIND_QUOTED ^ KIND_QUOTED ^ KIND_SYMBOL);
			end
			ST_QUOTE: begin
				if (c == CH_QUOTE) begin
					s = cont(ST_IDLE, c, KIND_QUOTED);
				end else if (c == CH_LF) begin
					s = cont(ST_IDLE, c, KIND_SKIP);
					s.res.err = ERR_NOCLOSE;
					s.nl = 1'b1;
				end else begin
					s = cont(ST_QUOTE, c, KIND_QUOTED);
				end
			end
			ST_NUM_INT: begin
				if (is_digit(c)) begin
					s = cont(ST_NUM_INT, c, KIND_NUMBER);
				end else if (c == CH_PERIOD) begin
					s = cont(ST_NUM_DOT, c, KIND_NUMBER);
					s.emit = 1'b0;
				end else if (c == CH_E_LO || c == CH_E_UP) begin
					s = cont(ST_NUM_EXP, c, KIND_NUMBER);
				end
			end
			ST_NUM_FRAC: begin
				if (is_digit(c))
					s = cont(ST_NUM_FRAC, c, KIND_NUMBER);
				else if (c == CH_E_LO || c == CH_E_UP)
					s = cont(ST_NUM_EXP, c, KIND_NUMBER);
			end
			ST_NUM_EXP: begin
				if (is_digit(c) || c == CH_PLUS || c == CH_MINUS)
					s = cont(ST_NUM_EXPDIG, c, KIND_NUMBER);
			end
			ST_NUM_EXPDIG: begin
				if (is_digit(c))
					s = cont(ST_NUM_EXPDIG, c, KIND_NUMBER);
			end
			ST_COMMENT: begin
				if (c != CH_LF)
					s = cont(ST_COMMENT, c, KIND_SKIP);
			end
			ST_PUNCT: begin
				if (is_punct(c) && !is_special(c) && c != CH_QUOTE)
					s = cont(ST_PUNCT, c, KIND_PUNCT);
			end
			ST_WORD: begin
				if (is_graph(c) && c != CH_PERIOD && c != CH_COMMA)
					s = cont(ST_WORD, c, KIND_WORD);
			end
			default: begin
			end
		endcase
		return s;
	endfunction

	// decide the results of this byte
	always_comb begin
		h = tok_handle(st_q, char_in, word_mode_q);
		emit0 = 1'b0;
		emit1 = 1'b0;
		bump = 1'b0;
		line_rst = 1'b0;
		st_nxt = st_q;
		q_res0 = h.res;
		q_res1 = h.res;
		if (end_of_input) begin
			line_rst = 1'b1;
			st_nxt = ST_IDLE;
			q_res1 = mk_res(CH_NUL, KIND_END, 1'b0,
				(st_q == ST_QUOTE) ? ERR_NOCLOSE : ERR_NONE);
			emit1 = 1'b1;
			if (st_q == ST_MINUS) begin
				emit0 = 1'b1;
				q_res0 = mk_res(CH_MINUS, KIND_PUNCT, 1'b1, ERR_NONE);
			end else if (st_q == ST_NUM_DOT) begin
				emit0 = 1'b1;
				q_res0 = mk_res(CH_PERIOD, KIND_SPECIAL, 1'b1, ERR_NONE);
			end else begin
				q_res0 = q_res1;
				emit0 = 1'b1;
				emit1 = 1'b0;
			end
		end else if (st_q == ST_MINUS || st_q == ST_NUM_DOT) begin
			// release the held byte, then label this one
			emit0 = 1'b1;
			if (is_digit(char_in)) begin
				emit1 = 1'b1;
				q_res1 = mk_res(char_in, KIND_NUMBER, 1'b0, ERR_NONE);
				if (st_q == ST_MINUS) begin
					q_res0 = mk_res(CH_MINUS, KIND_NUMBER, 1'b1, ERR_NONE);
					st_nxt = ST_NUM_INT;
				end else begin
					q_res0 = mk_res(CH_PERIOD, KIND_NUMBER, 1'b0, ERR_NONE);
					st_nxt = ST_NUM_FRAC;
				end
			end else begin
				if (st_q == ST_MINUS) begin
					q_res0 = mk_res(CH_MINUS, KIND_PUNCT, 1'b1, ERR_NONE);
					h = tok_handle(ST_PUNCT, char_in, word_mode_q);
				end else begin
					q_res0 = mk_res(CH_PERIOD, KIND_SPECIAL, 1'b1, ERR_NONE);
					h = tok_handle(ST_IDLE, char_in, word_mode_q);
				end
				emit1 = h.emit;
				q_res1 = h.res;
				bump = h.nl;
				st_nxt = h.st;
			end
		end else begin
			emit0 = h.emit;
			bump = h.nl;
			st_nxt = h.st;
		end
	end

	assign q_push = in_acc && emit0;
	assign q_two  = emit1;
	assign q_line = line_q;

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			word_mode_q <= 1'b0;
		else if (cfg_write)
			word_mode_q <= cfg_data;
	end

	// lexer state and saturating line count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			line_q <= LINE_ONE;
		end else if (in_acc) begin
			st_q <= st_nxt;
			if (line_rst)
				line_q <= LINE_ONE;
			else if (bump && line_q != LINE_MAX)
				line_q <= line_q + LINE_ONE;
		end
	end

endmodule

FILE: hdl/bst_back.sv
// Back end: queue of result pairs and serialiser that releases one result per transfer
module bst_back import bst_pkg::*; #(
	parameter int LINE_BITS = 16,
	parameter int DEPTH     = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 q_push,
	input  bst_res_t             q_res0,
	input  bst_res_t             q_res1,
	input  logic                 q_two,
	input  logic [LINE_BITS-1:0] q_line,
	output logic                 full,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           char_out,
	output logic [2:0]           kind,
	output logic                 token_start,
	output logic [LINE_BITS-1:0] line_number,
	output logic [1:0]           error_code,
	output logic                 last
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = 1 + 2 * RES_W + LINE_BITS;
	localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
	localparam logic [CW-1:0] CNT_ONE  = CW'(1);

	logic [EW-1:0] mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] cnt_q;
	logic          half_q;

	logic [EW-1:0]        head;
	logic                 head_two;
	bst_res_t             head_r0, head_r1, cur;
	logic [LINE_BITS-1:0] head_line;
	logic                 do_pop, retire;

	assign full  = (cnt_q == CNT_FULL);
	assign empty = (cnt_q == '0);

	// head entry and the result it currently shows
	assign head = mem_q[rd_ptr_q];
	assign {head_two, head_r1, head_r0, head_line} = head;
	assign cur = half_q ? head_r1 : head_r0;

	assign char_out    = cur.ch;
	assign kind        = cur.kind;
	assign token_start = cur.start;
	assign error_code  = cur.err;
	assign line_number = head_line;
	assign last        = half_q || !head_two;

	assign do_pop = pop && !empty;
	assign retire = do_pop && last;

	// entry storage
	always_ff @(posedge clk) begin
		if (q_push)
			mem_q[wr_ptr_q] <= {q_two, q_res1, q_res0, q_line};
	end

	// pointers, fill count and half select
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
			half_q <= 1'b0;
		end else begin
			if (q_push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PW'(1);
			if (retire)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PW'(1);
			if (do_pop)
				half_q <= !last;
			if (q_push && !retire)
				cnt_q <= cnt_q + CNT_ONE;
			else if (retire && !q_push)
				cnt_q <= cnt_q - CNT_ONE;
		end
	end

endmodule

FILE: hdl/byte_stream_tokenizer.sv
// Top level of the byte stream tokenizer
// Usage:
//   Input queue side: drive char_in / end_of_input with push; a byte transfers
//   on a clock edge with push high and full low. One byte per cycle is taken
//   while the result queue has room.
//   Result side: while empty is low the oldest result sits on char_out, kind,
//   token_start, line_number, error_code and last; pop transfers it.
//   Each input yields zero, one or two results; last marks the final one.
//   Outside word mode a minus at a token start or a period after number digits
//   yields nothing until the next input, which releases it ahead of its own result.
//   Results are registered in the result queue as their input transfers.
//   Throughput: one input per cycle while full is low, bounded by one result
//   per cycle at the result side, so an input that makes two results needs two pops.
//   A stalled receiver fills the QUEUE_DEPTH-entry result queue, then full rises.
//   Mode: cfg_write with cfg_data sets word mode; write only while idle.
//   Reset: full rules, lexer idle, line count one, queue empty.
`include "byte_stream_tokenizer_defines.svh"

module byte_stream_tokenizer import bst_pkg::*; #(
	parameter int LINE_BITS   = 16,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic                 cfg_data,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           char_in,
	input  logic                 end_of_input,
	output logic                 empty,
	input  logic                 pop,
	output logic [7:0]           char_out,
	output logic [2:0]           kind,
	output logic                 token_start,
	output logic [LINE_BITS-1:0] line_number,
	output logic [1:0]           error_code,
	output logic                 last
);

	logic                 in_acc;
	logic                 q_push, q_two;
	bst_res_t             q_res0, q_res1;
	logic [LINE_BITS-1:0] q_line;

	assign in_acc = push && !full;

	bst_front #(
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_acc       (in_acc),
		.char_in      (char_in),
		.end_of_input (end_of_input),
		.q_push       (q_push),
		.q_res0       (q_res0),
		.q_res1       (q_res1),
		.q_two        (q_two),
		.q_line       (q_line)
	);

	bst_back #(
		.LINE_BITS(LINE_BITS),
		.DEPTH    (QUEUE_DEPTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_push      (q_push),
		.q_res0      (q_res0),
		.q_res1      (q_res1),
		.q_two       (q_two),
		.q_line      (q_line),
		.full        (full),
		.empty       (empty),
		.pop         (pop),
		.char_out    (char_out),
		.kind        (kind),
		.token_start (token_start),
		.line_number (line_number),
		.error_code  (error_code),
		.last        (last)
	);

	// checks
	`BST_ASSERT_NOW(a_push_has_room, clk, arst_n, q_push, !full)
	`BST_ASSERT_NEXT(a_end_gives_result, clk, arst_n, in_acc && end_of_input, !empty)
	`BST_ASSERT_NOW(a_end_is_last, clk, arst_n, !empty && kind == KIND_END, last)
	`BST_ASSERT_NOW(a_line_nonzero, clk, arst_n, !empty, line_number != '0)

endmodule

FILE: bench/tb_top.sv
// Self-checking bench for the byte stream tokenizer: token streams in both modes, checked labels
`timescale 1ns / 100ps

module tb_top;
	import bst_pkg::*;

	// one byte (or end marker) bound for the tokenizer
	typedef struct packed {
		logic [7:0] ch;
		logic       eoi;
	} byte_item_t;

	// one labelled byte as it should leave the result side
	typedef struct packed {
		logic [7:0]  ch;
		logic [2:0]  kind;
		logic        start;
		logic [15:0] line;
		logic [1:0]  err;
		logic        last;
	} label_t;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        cfg_write    = 1'b0;
	logic        cfg_data     = 1'b0;
	logic        push         = 1'b0;
	logic [7:0]  char_in      = 8'h00;
	logic        end_of_input = 1'b0;
	logic        pop          = 1'b0;
	logic        full;
	logic        empty;
	logic [7:0]  char_out;
	logic [2:0]  kind;
	logic        token_start;
	logic [15:0] line_number;
	logic [1:0]  error_code;
	logic        last;

	byte_item_t bytes_waiting[$];
	label_t     labels_due[$];
	label_t     step_out[$];

	// predicted lexer state
	logic [3:0]  tok_state  = ST_IDLE;
	logic [15:0] line_cnt   = 16'd1;
	logic        word_rules = 1'b0;

	logic took_in    = 1'b0;
	int   bad_count  = 0;
	int   fed        = 0;
	int   burst_left = 0;
	int   gap_left   = 0;
	int   pat_mode   = 0;
	int   pat_left   = 0;

	byte_stream_tokenizer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_data    (cfg_data),
		.push        (push),
		.full        (full),
		.char_in     (char_in),
		.end_of_input(end_of_input),
		.empty       (empty),
		.pop         (pop),
		.char_out    (char_out),
		.kind        (kind),
		.token_start (token_start),
		.line_number (line_number),
		.error_code  (error_code),
		.last        (last)
	);

	always #6 clk = ~clk;

	// character classes
	function automatic logic blank_ch(input logic [7:0] c);
		return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic digit_ch(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic letter_ch(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic graph_ch(input logic [7:0] c);
		return c >= 8'd33 && c <= 8'd126;
	endfunction

	function automatic logic punct_ch(input logic [7:0] c);
		return graph_ch(c) && !digit_ch(c) && !letter_ch(c);
	endfunction

	function automatic logic special_ch(input logic [7:0] c);
		return c == CH_COMMA || c == CH_PERIOD || c == CH_LPAREN ||
			c == CH_RPAREN || c == CH_QMARK;
	endfunction

	task automatic add_label(input logic [7:0] c, input logic [2:0] k, input logic s,
		input logic [1:0] e);
		label_t lb;
		lb.ch = c;
		lb.kind = k;
		lb.start = s;
		lb.line = line_cnt;
		lb.err = e;
		lb.last = 1'b0;
		step_out.push_back(lb);
	endtask

	task automatic bump_line();
		if (line_cnt != 16'hFFFF)
			line_cnt++;
	endtask

	// byte at a token boundary; mode only matters here
	task automatic fresh_token(input logic [7:0] c);
		tok_state = ST_IDLE;
		if (blank_ch(c)) begin
			add_label(c, KIND_SKIP, 1'b0, ERR_NONE);
			if (c == CH_LF)
				bump_line();
		end else if (c == CH_QUOTE) begin
			tok_state = ST_QUOTE;
			add_label(c, KIND_QUOTED, 1'b1, ERR_NONE);
		end else if (word_rules) begin
			if (c == CH_PERIOD || c == CH_COMMA) begin
				add_label(c, KIND_SPECIAL, 1'b1, ERR_NONE);
			end else if (graph_ch(c)) begin
				tok_state = ST_WORD;
				add_label(c, KIND_WORD, 1'b1, ERR_NONE);
			end else begin
				add_label(c, KIND_SKIP, 1'b0, ERR_ILLEGAL);
			end
		end else if (letter_ch(c) || c == CH_UNDER) begin
			tok_state = ST_SYMBOL;
			add_label(c, KIND_SYMBOL, 1'b1, ERR_NONE);
		end else if (digit_ch(c)) begin
			tok_state = ST_NUM_INT;
			add_label(c, KIND_NUMBER, 1'b1, ERR_NONE);
		end else if (c == CH_PERCENT) begin
			tok_state = ST_COMMENT;
			add_label(c, KIND_SKIP, 1'b0, ERR_NONE);
		end else if (c == CH_MINUS) begin
			// held until the next byte says number or punct
			tok_state = ST_MINUS;
		end else if (special_ch(c)) begin
			add_label(c, KIND_SPECIAL, 1'b1, ERR_NONE);
		end else if (punct_ch(c)) begin
			tok_state = ST_PUNCT;
			add_label(c, KIND_PUNCT, 1'b1, ERR_NONE);
		end else begin
			add_label(c, KIND_SKIP, 1'b0, ERR_ILLEGAL);
		end
	endtask

	// byte inside a token; anything that does not fit starts afresh
	task automatic continue_token(input logic [7:0] c);
		logic kept;
		kept = 1'b1;
		case (tok_state)
			ST_SYMBOL: begin
				if (letter_ch(c) || digit_ch(c) || c == CH_UNDER)
					add_label(c, KIND_SYMBOL, 1'b0, ERR_NONE);
				else
					kept = 1'b0;
			end
			ST_QUOTE: begin
				if (c == CH_QUOTE) begin
					add_label(c, KIND_QUOTED, 1'b0, ERR_NONE);
					tok_state = ST_IDLE;
				end else if (c == CH_LF) begin
					add_label(c, KIND_SKIP, 1'b0, ERR_NOCLOSE);
					bump_line();
					tok_state = ST_IDLE;
				end else begin
					add_label(c, KIND_QUOTED, 1'b0, ERR_NONE);
				end
			end
			ST_NUM_INT: begin
				if (digit_ch(c)) begin
					add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
				end else if (c == CH_PERIOD) begin
					tok_state = ST_NUM_DOT;
				end else if (c == CH_E_LO || c == CH_E_UP) begin
					add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
					tok_state = ST_NUM_EXP;
				end else begin
					kept = 1'b0;
				end
			end
			ST_NUM_FRAC: begin
				if (digit_ch(c)) begin
					add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
				end else if (c == CH_E_LO || c == CH_E_UP) begin
					add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
					tok_state = ST_NUM_EXP;
				end else begin
					kept = 1'b0;
				end
			end
			ST_NUM_EXP: begin
				if (digit_ch(c) || c == CH_PLUS || c == CH_MINUS) begin
					add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
					tok_state = ST_NUM_EXPDIG;
				end else begin
					kept = 1'b0;
				end
			end
			ST_NUM_EXPDIG: begin
				if (digit_ch(c))
					add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
				else
					kept = 1'b0;
			end
			ST_COMMENT: begin
				if (c != CH_LF)
					add_label(c, KIND_SKIP, 1'b0, ERR_NONE);
				else
					kept = 1'b0;
			end
			ST_PUNCT: begin
				if (punct_ch(c) && !special_ch(c) && c != CH_QUOTE)
					add_label(c, KIND_PUNCT, 1'b0, ERR_NONE);
				else
					kept = 1'b0;
			end
			ST_WORD: begin
				if (graph_ch(c) && c != CH_PERIOD && c != CH_COMMA)
					add_label(c, KIND_WORD, 1'b0, ERR_NONE);
				else
					kept = 1'b0;
			end
			default: kept = 1'b0;
		endcase
		if (!kept)
			fresh_token(c);
	endtask

	// labels caused by one accepted transfer, held bytes released first
	task automatic predict_labels(input logic [7:0] c, input logic eoi);
		logic [3:0] was;
		label_t     tail;
		was = tok_state;
		step_out.delete();
		if (eoi) begin
			if (was == ST_MINUS)
				add_label(CH_MINUS, KIND_PUNCT, 1'b1, ERR_NONE);
			else if (was == ST_NUM_DOT)
				add_label(CH_PERIOD, KIND_SPECIAL, 1'b1, ERR_NONE);
			add_label(CH_NUL, KIND_END, 1'b0, (was == ST_QUOTE) ? ERR_NOCLOSE : ERR_NONE);
			tok_state = ST_IDLE;
			line_cnt = 16'd1;
		end else if (was == ST_MINUS) begin
			if (digit_ch(c)) begin
				add_label(CH_MINUS, KIND_NUMBER, 1'b1, ERR_NONE);
				add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
				tok_state = ST_NUM_INT;
			end else begin
				add_label(CH_MINUS, KIND_PUNCT, 1'b1, ERR_NONE);
				tok_state = ST_PUNCT;
				continue_token(c);
			end
		end else if (was == ST_NUM_DOT) begin
			if (digit_ch(c)) begin
				add_label(CH_PERIOD, KIND_NUMBER, 1'b0, ERR_NONE);
				add_label(c, KIND_NUMBER, 1'b0, ERR_NONE);
				tok_state = ST_NUM_FRAC;
			end else begin
				add_label(CH_PERIOD, KIND_SPECIAL, 1'b1, ERR_NONE);
				tok_state = ST_IDLE;
				continue_token(c);
			end
		end else begin
			continue_token(c);
		end
		if (step_out.size() > 0) begin
			tail = step_out.pop_back();
			tail.last = 1'b1;
			step_out.push_back(tail);
		end
		while (step_out.size() > 0)
			labels_due.push_back(step_out.pop_front());
	endtask

	task automatic flag_bad(input string what, input label_t want, input label_t got);
		bad_count++;
		if (bad_count <= 10) begin
			$display("%0t %s: want ch=%h kind=%0d start=%b line=%0d err=%0d last=%b",
				$realtime, what, want.ch, want.kind, want.start, want.line, want.err,
				want.last);
			$display("    got ch=%h kind=%0d start=%b line=%0d err=%0d last=%b",
				got.ch, got.kind, got.start, got.line, got.err, got.last);
		end
	endtask

	// monitor: input transfers feed the predictor, result transfers are checked
	always @(posedge clk) begin : watch_proc
		label_t got;
		label_t want;
		took_in = arst_n && push && !full;
		if (took_in)
			predict_labels(char_in, end_of_input);
		if (arst_n && pop && !empty) begin
			got.ch = char_out;
			got.kind = kind;
			got.start = token_start;
			got.line = line_number;
			got.err = error_code;
			got.last = last;
			if (labels_due.size() == 0) begin
				want = '0;
				flag_bad("unexpected result", want, got);
			end else begin
				want = labels_due.pop_front();
				if (got !== want)
					flag_bad("label mismatch", want, got);
			end
		end
	end

	// driver: bursts of transfers with random gaps
	always @(negedge clk) begin : feed_proc
		byte_item_t it;
		if (!arst_n) begin
			push <= 1'b0;
		end else if (!push || took_in) begin
			if (gap_left > 0) begin
				gap_left--;
				push <= 1'b0;
			end else if (bytes_waiting.size() > 0) begin
				it = bytes_waiting.pop_front();
				char_in <= it.ch;
				end_of_input <= it.eoi;
				push <= 1'b1;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
				end
			end else begin
				push <= 1'b0;
			end
		end
	end

	// receiver: switches between free flow, random, sparse and long stalls
	always @(negedge clk) begin : drain_proc
		if (pat_left == 0) begin
			pat_mode = $urandom_range(0, 3);
			pat_left = $urandom_range(20, 200);
		end else begin
			pat_left--;
		end
		case (pat_mode)
			0: pop <= 1'b1;
			1: pop <= 1'($urandom_range(0, 1));
			2: pop <= ($urandom_range(0, 3) == 0);
			default: pop <= ((pat_left % 16) >= 12);
		endcase
	end

	task automatic put_byte(input logic [7:0] c);
		byte_item_t it;
		it.ch = c;
		it.eoi = 1'b0;
		bytes_waiting.push_back(it);
		fed++;
	endtask

	task automatic put_end();
		byte_item_t it;
		it.ch = 8'($urandom_range(0, 255));
		it.eoi = 1'b1;
		bytes_waiting.push_back(it);
		fed++;
	endtask

	task automatic put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			put_byte(s[i]);
	endtask

	function automatic logic [7:0] any_of(input string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	// one well-formed token with random content, or a stray byte
	task automatic put_token();
		int pick;
		int n;
		logic [7:0] c;
		pick = $urandom_range(0, 99);
		if (pick < 14) begin
			put_byte(any_of("_abcxyzQEe"));
			n = $urandom_range(0, 6);
			repeat (n) put_byte(any_of("_azAZ09eE5"));
		end else if (pick < 30) begin
			// number: optional minus, fraction, exponent
			if ($urandom_range(0, 3) == 0)
				put_byte(CH_MINUS);
			n = $urandom_range(1, 4);
			repeat (n) put_byte(any_of("0123456789"));
			case ($urandom_range(0, 3))
				0: begin
					put_byte(CH_PERIOD);
					n = $urandom_range(1, 3);
					repeat (n) put_byte(any_of("0123456789"));
				end
				1: put_byte(CH_PERIOD);
				default: ;
			endcase
			if ($urandom_range(0, 3) == 0) begin
				put_byte($urandom_range(0, 1) ? CH_E_LO : CH_E_UP);
				case ($urandom_range(0, 2))
					0: put_byte(CH_PLUS);
					1: put_byte(CH_MINUS);
					default: ;
				endcase
				n = $urandom_range(0, 3);
				repeat (n) put_byte(any_of("0123456789"));
			end
		end else if (pick < 40) begin
			// quoted text, sometimes cut by a newline
			put_byte(CH_QUOTE);
			n = $urandom_range(0, 6);
			repeat (n) begin
				c = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(128, 255))
					: 8'($urandom_range(32, 126));
				put_byte((c == CH_QUOTE) ? CH_UNDER : c);
			end
			put_byte(($urandom_range(0, 6) == 0) ? CH_LF : CH_QUOTE);
		end else if (pick < 48) begin
			put_byte(any_of("(),.?"));
		end else if (pick < 56) begin
			n = $urandom_range(1, 4);
			repeat (n) put_byte(any_of("!#$&*+-/:;<=>@[\\]^`{|}~\""));
		end else if (pick < 61) begin
			put_byte(CH_PERCENT);
			n = $urandom_range(0, 8);
			repeat (n) begin
				c = 8'($urandom_range(0, 255));
				put_byte((c == CH_LF) ? CH_QUOTE : c);
			end
			put_byte(CH_LF);
		end else if (pick < 75) begin
			n = $urandom_range(0, 5);
			put_byte((n == 5) ? 8'd32 : 8'd9 + n[7:0]);
		end else if (pick < 82) begin
			n = $urandom_range(1, 6);
			repeat (n) put_byte(8'($urandom_range(33, 126)));
		end else if (pick < 89) begin
			put_byte(CH_MINUS);
			put_byte(any_of("-+a.(' 5%"));
		end else begin
			put_byte(8'($urandom_range(0, 255)));
		end
	endtask

	// mode register, written only with nothing in flight
	task automatic set_word_mode(input logic v);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		word_rules = v;
	endtask

	// hold off until every queued byte has gone and every label has come back
	task automatic wait_idle();
		int spin;
		spin = 0;
		while ((bytes_waiting.size() != 0 || push || labels_due.size() != 0) &&
			spin < 200000) begin
			@(posedge clk);
			spin++;
		end
		repeat (4) @(negedge clk);
	endtask

	initial begin : stim_proc
		int phase;
		int target;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		set_word_mode(1'b0);

		// directed: every kind, illegal bytes, cut quote, lone minus, period after digits
		put_text("x_9 -7.5e+3 1.a -+");
		put_byte(8'hFF);
		put_byte(CH_NUL);
		put_text("'q");
		put_byte(CH_LF);
		put_text("(-");
		put_end();
		// symbol open across a switch to word rules, then end with an open quote
		put_text("ab");
		wait_idle();
		set_word_mode(1'b1);
		put_text("c.d 'w");
		put_end();
		wait_idle();

		// random token streams, alternating modes; some phases stop mid-token
		fed = 0;
		phase = 0;
		while (fed < 1450) begin
			set_word_mode(phase[0]);
			target = fed + $urandom_range(120, 260);
			while (fed < target) begin
				put_token();
				if ($urandom_range(0, 19) == 0)
					put_end();
			end
			if ($urandom_range(0, 4) != 0)
				put_end();
			wait_idle();
			phase++;
		end

		// newlines in and out of quotes, then end markers bring the line count back to one
		set_word_mode(1'b0);
		put_byte(CH_LF);
		put_text("x'y");
		put_byte(CH_LF);
		put_text("1");
		put_end();
		put_text("z");
		put_end();
		wait_idle();

		if (bad_count == 0 && labels_due.size() == 0)
			$display("byte_stream_tokenizer test passed");
		else
			$display("byte_stream_tokenizer test failed");
		$finish;
	end

	// watchdog
	initial begin
		#5_000_000;
		$display("byte_stream_tokenizer test failed");
		$finish;
	end

endmodule
